// ===== sv/ttd_pkg.sv =====
`default_nettype none

package ttd_pkg;

    // Request and result layout
    localparam int REQUEST_W    = 32;
    localparam int RESULT_W     = 40;
    localparam int CHAR_W       = 8;
    localparam int PIXEL_X_W    = 10;
    localparam int PIXEL_Y_W    = 9;
    localparam int COLOUR_W     = 8;
    localparam int CURSOR_COL_W = 7;
    localparam int CURSOR_ROW_W = 5;

    // Request kinds carried on tuser
    localparam logic OP_PUT   = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // Character codes with a meaning of their own
    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
    localparam logic [CHAR_W-1:0] CR_CODE    = 8'h0d;
    localparam logic [CHAR_W-1:0] LF_CODE    = 8'h0a;
    localparam logic [CHAR_W-1:0] BS_CODE    = 8'h08;
    localparam logic [CHAR_W-1:0] LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] LOWER_Z    = 8'h7a;
    localparam logic [CHAR_W-1:0] CASE_SHIFT = 8'h20;

    // Output colours, lit and dark
    localparam logic [COLOUR_W-1:0] RED_LIT    = 8'd80;
    localparam logic [COLOUR_W-1:0] GREEN_LIT  = 8'd255;
    localparam logic [COLOUR_W-1:0] BLUE_LIT   = 8'd120;
    localparam logic [COLOUR_W-1:0] RED_DARK   = 8'd4;
    localparam logic [COLOUR_W-1:0] GREEN_DARK = 8'd16;
    localparam logic [COLOUR_W-1:0] BLUE_DARK  = 8'd8;

    // 5x7 glyph, font row 0 in the top bits, bit 4 of a row is the leftmost dot
    function automatic logic [34:0] glyph(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] c;
        c = code;
        if (c >= LOWER_A && c <= LOWER_Z) begin
            c = c - CASE_SHIFT;
        end
        case (c)
            8'h30: return {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
            8'h31: return {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
            8'h32: return {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
            8'h33: return {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
            8'h34: return {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
            8'h35: return {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
            8'h36: return {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
            8'h37: return {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            8'h38: return {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
            8'h39: return {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
            8'h41: return {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
            8'h42: return {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
            8'h43: return {5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e};
            8'h44: return {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
            8'h45: return {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
            8'h46: return {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10};
            8'h47: return {5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f};
            8'h48: return {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
            8'h49: return {5'h0e, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
            8'h4a: return {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0c};
            8'h4b: return {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            8'h4c: return {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f};
            8'h4d: return {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            8'h4e: return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            8'h4f: return {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
            8'h50: return {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
            8'h51: return {5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d};
            8'h52: return {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
            8'h53: return {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
            8'h54: return {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h55: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
            8'h56: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04};
            8'h57: return {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0a};
            8'h58: return {5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11};
            8'h59: return {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04};
            8'h5a: return {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f};
            // period, comma, colon, dash, slash, exclamation mark
            8'h2e: return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04};
            8'h2c: return {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h08};
            8'h3a: return {5'h00, 5'h04, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00};
            8'h2d: return {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
            8'h2f: return {5'h00, 5'h00, 5'h10, 5'h08, 5'h04, 5'h02, 5'h01};
            8'h21: return {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
            default: return '0;
        endcase
    endfunction

    // One font row of a code; rows past the glyph are blank
    function automatic logic [4:0] font_row(input logic [CHAR_W-1:0] code,
                                            input logic [2:0] r);
        logic [34:0] g;
        g = glyph(code);
        case (r)
            3'd0: return g[34:30];
            3'd1: return g[29:25];
            3'd2: return g[24:20];
            3'd3: return g[19:15];
            3'd4: return g[14:10];
            3'd5: return g[9:5];
            3'd6: return g[4:0];
            default: return '0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== sv/text_terminal_display_unit.sv =====
`default_nettype none

// Channel  Direction  tuser          tdata (lowest bit first)
// s_       in         op             char_code[7:0], pixel_x[17:8], pixel_y[26:18]
// m_       out        -              pixel_on[0], red[8:1], green[16:9], blue[24:17],
//                                    cursor_col[31:25], cursor_row[36:32]
//
// Steps: a put request passes ST_PUT, then ST_SCROLL when a line feed or a
// wrap scrolls the screen (the bottom line is wiped one cell a cycle); a pixel fetch
// passes ST_MUL and ST_DIV (reciprocal divide), ST_ADDR (cell read) and ST_GLYPH.
// Reset: after aresetn rises the cell memory is filled with spaces, ROWS * 2**COL_W
// cells (3072 at the default size), with s_tready low.
// Stalls: one request is in work at a time; the next is taken while the last result
// still waits in the output register.

module text_terminal_display_unit
    import ttd_pkg::*;
#(
    parameter int COLUMNS     = 80,
    parameter int ROWS        = 24,
    parameter int CELL_WIDTH  = 8,
    parameter int CELL_HEIGHT = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [REQUEST_W-1:0] s_tdata,  // char_code, pixel_x, pixel_y
    input  logic                 s_tuser,  // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [RESULT_W-1:0]  m_tdata   // pixel_on, red, green, blue,
                                           // cursor_col, cursor_row
);

    localparam int COL_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DEPTH     = ROWS * (1 << COL_W);
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RECIP_SH  = 16;
    localparam int MX        = (1 << RECIP_SH) / CELL_WIDTH;
    localparam int MY        = (1 << RECIP_SH) / CELL_HEIGHT;
    localparam int PRODX_W   = PIXEL_X_W + RECIP_SH + 1;
    localparam int PRODY_W   = PIXEL_Y_W + RECIP_SH + 1;
    localparam int QX_W      = $clog2(((1 << PIXEL_X_W) - 1) / CELL_WIDTH + 1);
    localparam int QY_W      = $clog2(((1 << PIXEL_Y_W) - 1) / CELL_HEIGHT + 1);
    localparam int RX_W      = $clog2(2 * CELL_WIDTH);
    localparam int RY_W      = $clog2(2 * CELL_HEIGHT);
    localparam int XW        = $clog2(CELL_WIDTH);
    localparam int YW        = $clog2(CELL_HEIGHT);
    localparam int COL_EXT_W = COL_W + CURSOR_COL_W;
    localparam int ROW_EXT_W = ROW_W + CURSOR_ROW_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT,
        ST_SCROLL,
        ST_MUL,
        ST_DIV,
        ST_ADDR,
        ST_GLYPH,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic                  op_reg, op_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic [PIXEL_X_W-1:0]  px_reg, px_next;
    logic [PIXEL_Y_W-1:0]  py_reg, py_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      line_reg, line_next;
    logic [ROW_W-1:0]      top_reg, top_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    logic [ROW_W-1:0]      scroll_row_reg, scroll_row_next;
    logic [COL_W-1:0]      scroll_col_reg, scroll_col_next;
    logic [QX_W-1:0]       qx_reg, qx_next;
    logic [QY_W-1:0]       qy_reg, qy_next;
    logic [RX_W-1:0]       rx_reg, rx_next;
    logic [RY_W-1:0]       ry_reg, ry_next;
    logic [XW-1:0]         x_reg, x_next;
    logic [YW-1:0]         y_reg, y_next;
    logic                  inside_reg, inside_next;
    logic                  lit_reg, lit_next;
    logic                  m_valid_reg, m_valid_next;
    logic [RESULT_W-1:0]   m_data_reg, m_data_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [CHAR_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [CHAR_W-1:0]     ram_rdata;

    logic [PRODX_W-1:0]    prod_x;
    logic [PRODY_W-1:0]    prod_y;
    logic [PIXEL_X_W-1:0]  rx_full;
    logic [PIXEL_Y_W-1:0]  ry_full;
    logic                  x_over, y_over;
    logic [QX_W-1:0]       qx_fix;
    logic [QY_W-1:0]       qy_fix;
    logic [ROW_W-1:0]      pix_row;
    logic [ROW_W-1:0]      line_row;
    logic [COL_W-1:0]      bs_col;
    logic                  newline;
    logic [7:0]            xi, fr;
    logic [2:0]            bit_sel;
    logic [4:0]            row_bits;
    logic [COL_EXT_W-1:0]  col_ext;
    logic [ROW_EXT_W-1:0]  row_ext;
    logic [COLOUR_W-1:0]   red_v, green_v, blue_v;
    logic                  on_v;

    // Logical line to memory row, rotated by the scroll offset
    function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] t);
        logic [ROW_W:0] s;
        s = {1'b0, r} + {1'b0, t};
        if (s >= (ROW_W + 1)'(ROWS)) begin
            s = s - (ROW_W + 1)'(ROWS);
        end
        return s[ROW_W-1:0];
    endfunction

    ttd_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pixel arithmetic: reciprocal products, remainders, one correction step
    always_comb begin
        prod_x  = PRODX_W'(px_reg) * PRODX_W'(MX);
        prod_y  = PRODY_W'(py_reg) * PRODY_W'(MY);
        rx_full = px_reg - PIXEL_X_W'(PIXEL_X_W'(qx_reg) * PIXEL_X_W'(CELL_WIDTH));
        ry_full = py_reg - PIXEL_Y_W'(PIXEL_Y_W'(qy_reg) * PIXEL_Y_W'(CELL_HEIGHT));
        x_over  = rx_reg >= RX_W'(CELL_WIDTH);
        y_over  = ry_reg >= RY_W'(CELL_HEIGHT);
        qx_fix  = x_over ? QX_W'(qx_reg + QX_W'(1)) : qx_reg;
        qy_fix  = y_over ? QY_W'(qy_reg + QY_W'(1)) : qy_reg;
        pix_row = wrap_row(ROW_W'(qy_fix), top_reg);
        line_row = wrap_row(line_reg, top_reg);
        bs_col  = (col_reg != '0) ? COL_W'(col_reg - COL_W'(1)) : col_reg;
    end

    // Glyph lookup on the cell read back from memory
    always_comb begin
        xi       = 8'(x_reg);
        fr       = (8'(y_reg) - 8'd1) >> 1;
        bit_sel  = 3'(8'd5 - xi);
        row_bits = font_row(ram_rdata, fr[2:0]);
    end

    assign ram_raddr = ADDR_W'({pix_row, COL_W'(qx_fix)});

    // Sequencer: next state, memory writes and result
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        char_next       = char_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        col_next        = col_reg;
        line_next       = line_reg;
        top_next        = top_reg;
        clr_addr_next   = clr_addr_reg;
        scroll_row_next = scroll_row_reg;
        scroll_col_next = scroll_col_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        rx_next         = rx_reg;
        ry_next         = ry_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        inside_next     = inside_reg;
        lit_next        = lit_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = clr_addr_reg;
        ram_wdata       = SPACE_CODE;
        newline         = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                // fill every cell with a space
                ram_we = 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = ADDR_W'(clr_addr_reg + ADDR_W'(1));
                end
            end
            ST_IDLE: begin
                // take a request
                if (s_tvalid) begin
                    op_next   = s_tuser;
                    char_next = s_tdata[7:0];
                    px_next   = s_tdata[17:8];
                    py_next   = s_tdata[26:18];
                    state_next = (s_tuser == OP_FETCH) ? ST_MUL : ST_PUT;
                end
            end
            ST_PUT: begin
                state_next = ST_DONE;
                if (char_reg == CR_CODE) begin
                    col_next = '0;
                end else if (char_reg == LF_CODE) begin
                    newline = 1'b1;
                end else if (char_reg == BS_CODE) begin
                    // step left where possible and blank the cell
                    col_next  = bs_col;
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'({line_row, bs_col});
                end else if (char_reg >= SPACE_CODE) begin
                    // store and advance, wrap at the row end
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'({line_row, col_reg});
                    ram_wdata = char_reg;
                    if (col_reg == COL_W'(COLUMNS - 1)) begin
                        newline = 1'b1;
                    end else begin
                        col_next = COL_W'(col_reg + COL_W'(1));
                    end
                end
                if (newline) begin
                    col_next = '0;
                    if (line_reg == ROW_W'(ROWS - 1)) begin
                        // scroll: old top row becomes the new bottom line
                        top_next = (top_reg == ROW_W'(ROWS - 1)) ? '0
                                 : ROW_W'(top_reg + ROW_W'(1));
                        scroll_row_next = top_reg;
                        scroll_col_next = '0;
                        state_next      = ST_SCROLL;
                    end else begin
                        line_next = ROW_W'(line_reg + ROW_W'(1));
                    end
                end
            end
            ST_SCROLL: begin
                // wipe the new bottom line one cell a cycle
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'({scroll_row_reg, scroll_col_reg});
                if (scroll_col_reg == COL_W'(COLUMNS - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    scroll_col_next = COL_W'(scroll_col_reg + COL_W'(1));
                end
            end
            ST_MUL: begin
                qx_next    = prod_x[RECIP_SH +: QX_W];
                qy_next    = prod_y[RECIP_SH +: QY_W];
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rx_next    = rx_full[RX_W-1:0];
                ry_next    = ry_full[RY_W-1:0];
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                // cell read is issued here through ram_raddr
                x_next      = XW'(x_over ? RX_W'(rx_reg - RX_W'(CELL_WIDTH)) : rx_reg);
                y_next      = YW'(y_over ? RY_W'(ry_reg - RY_W'(CELL_HEIGHT)) : ry_reg);
                inside_next = (16'(qx_fix) < 16'(COLUMNS)) && (16'(qy_fix) < 16'(ROWS));
                state_next  = ST_GLYPH;
            end
            ST_GLYPH: begin
                lit_next = inside_reg && (y_reg != '0) && (fr <= 8'd6)
                        && (xi >= 8'd1) && (xi <= 8'd5) && row_bits[bit_sel];
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hand the result over once the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, row_ext[CURSOR_ROW_W-1:0],
                                    col_ext[CURSOR_COL_W-1:0],
                                    blue_v, green_v, red_v, on_v};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result fields
    always_comb begin
        col_ext = COL_EXT_W'(col_reg);
        row_ext = ROW_EXT_W'(line_reg);
        if (op_reg == OP_PUT) begin
            on_v    = 1'b0;
            red_v   = '0;
            green_v = '0;
            blue_v  = '0;
        end else begin
            on_v    = lit_reg;
            red_v   = lit_reg ? RED_LIT : RED_DARK;
            green_v = lit_reg ? GREEN_LIT : GREEN_DARK;
            blue_v  = lit_reg ? BLUE_LIT : BLUE_DARK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            col_reg      <= '0;
            line_reg     <= '0;
            top_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            col_reg      <= col_next;
            line_reg     <= line_next;
            top_reg      <= top_next;
            m_valid_reg  <= m_valid_next;
        end
        op_reg         <= op_next;
        char_reg       <= char_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        scroll_row_reg <= scroll_row_next;
        scroll_col_reg <= scroll_col_next;
        qx_reg         <= qx_next;
        qy_reg         <= qy_next;
        rx_reg         <= rx_next;
        ry_reg         <= ry_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        inside_reg     <= inside_next;
        lit_reg        <= lit_next;
        m_data_reg     <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== sv/ttd_ram.sv =====
`default_nettype none

module ttd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/ttd_checker.sv =====
`default_nettype none

module ttd_checker
    import ttd_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [RESULT_W-1:0] m_tdata
);

    // Reset leaves the block busy clearing, with no result pending
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("request taken or result shown right after reset");

    // One request in work at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in work");

    // A stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // A lit pixel carries the lit colour
    a_lit_colour: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[24:1] == {BLUE_LIT, GREEN_LIT, RED_LIT})
        else $error("lit pixel with wrong colour");

    // Cursor stays on screen
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (16'(m_tdata[31:25]) < 16'(COLUMNS))
                  && (16'(m_tdata[36:32]) < 16'(ROWS)))
        else $error("cursor off screen");

endmodule

bind text_terminal_display_unit ttd_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_ttd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/tb_text_terminal_display_unit.sv =====
`timescale 1ns / 1ps

module tb_text_terminal_display_unit;
    import ttd_pkg::*;

    localparam int TERM_COLS    = 80;
    localparam int TERM_ROWS    = 24;
    localparam int GLYPH_W      = 8;
    localparam int GLYPH_H      = 16;
    localparam int STORE_LEN    = TERM_COLS * TERM_ROWS;
    localparam int DIRECTED     = 25;
    localparam int RANDOM_ITEMS = 925;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_REPORTS  = 20;

    // Result fields, cursor_row in the top bits down to pixel_on in bit 0
    typedef struct packed {
        logic [CURSOR_ROW_W-1:0] cursor_row;
        logic [CURSOR_COL_W-1:0] cursor_col;
        logic [COLOUR_W-1:0]     blue;
        logic [COLOUR_W-1:0]     green;
        logic [COLOUR_W-1:0]     red;
        logic                    pixel_on;
    } pixel_result_t;

    // Mirror of the screen and cursor; holds the results still owed by the block
    class screen_scoreboard;
        logic [CHAR_W-1:0]       screen_codes [STORE_LEN];
        logic [CURSOR_COL_W-1:0] col_now;
        logic [CURSOR_ROW_W-1:0] row_now;
        pixel_result_t           awaited [$];
        int errors;
        int puts;
        int fetches;
        int lit;
        int scrolls;
        int wraps;
        int checked;

        function new();
            foreach (screen_codes[i]) screen_codes[i] = SPACE_CODE;
            col_now = '0;
            row_now = '0;
            errors  = 0;
            puts    = 0;
            fetches = 0;
            lit     = 0;
            scrolls = 0;
            wraps   = 0;
            checked = 0;
        endfunction

        // 5x7 dots of one font row, leftmost dot in bit 4
        function logic [4:0] glyph_dots(logic [CHAR_W-1:0] code, int r);
            logic [4:0]        g [7];
            logic [CHAR_W-1:0] c;
            c = code;
            g = '{default: 5'h00};
            if (c >= LOWER_A && c <= LOWER_Z) begin
                c = c - CASE_SHIFT;
            end
            case (c)
                "0": g = '{5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
                "1": g = '{5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
                "2": g = '{5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
                "3": g = '{5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
                "4": g = '{5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
                "5": g = '{5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
                "6": g = '{5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
                "7": g = '{5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
                "8": g = '{5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
                "9": g = '{5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
                "A": g = '{5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
                "B": g = '{5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
                "C": g = '{5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e};
                "D": g = '{5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
                "E": g = '{5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
                "F": g = '{5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10};
                "G": g = '{5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f};
                "H": g = '{5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
                "I": g = '{5'h0e, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
                "J": g = '{5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0c};
                "K": g = '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
                "L": g = '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f};
                "M": g = '{5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
                "N": g = '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
                "O": g = '{5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
                "P": g = '{5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
                "Q": g = '{5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d};
                "R": g = '{5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
                "S": g = '{5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
                "T": g = '{5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
                "U": g = '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
                "V": g = '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04};
                "W": g = '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0a};
                "X": g = '{5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11};
                "Y": g = '{5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04};
                "Z": g = '{5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f};
                ".": g = '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04};
                ",": g = '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h08};
                ":": g = '{5'h00, 5'h04, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00};
                "-": g = '{5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
                // the diagonal spans five rows, so its top two rows stay dark
                "/": g = '{5'h00, 5'h00, 5'h10, 5'h08, 5'h04, 5'h02, 5'h01};
                "!": g = '{5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
                default: ;
            endcase
            return (r >= 0 && r <= 6) ? g[r] : 5'h00;
        endfunction

        // Return to column zero on the next line, scroll up when past the bottom
        function void next_line();
            col_now = '0;
            if (row_now == TERM_ROWS - 1) begin
                for (int i = 0; i < STORE_LEN - TERM_COLS; i++) begin
                    screen_codes[i] = screen_codes[i + TERM_COLS];
                end
                for (int i = STORE_LEN - TERM_COLS; i < STORE_LEN; i++) begin
                    screen_codes[i] = SPACE_CODE;
                end
                scrolls++;
            end else begin
                row_now++;
            end
        endfunction

        function void print_code(logic [CHAR_W-1:0] code);
            case (code)
                CR_CODE: col_now = '0;
                LF_CODE: next_line();
                BS_CODE: begin
                    // step left where possible and blank whatever is under the cursor
                    if (col_now != 0) begin
                        col_now--;
                    end
                    screen_codes[row_now * TERM_COLS + col_now] = SPACE_CODE;
                end
                default: begin
                    // other control codes leave everything as it is
                    if (code >= SPACE_CODE) begin
                        screen_codes[row_now * TERM_COLS + col_now] = code;
                        if (col_now == TERM_COLS - 1) begin
                            wraps++;
                            next_line();
                        end else begin
                            col_now++;
                        end
                    end
                end
            endcase
        endfunction

        function bit pixel_lit(logic [PIXEL_X_W-1:0] px, logic [PIXEL_Y_W-1:0] py);
            int         col;
            int         row;
            int         x;
            int         y;
            logic [4:0] dots;
            col = px / GLYPH_W;
            row = py / GLYPH_H;
            x   = px % GLYPH_W;
            y   = py % GLYPH_H;
            if (col >= TERM_COLS || row >= TERM_ROWS) begin
                return 1'b0;
            end
            // top pixel row, rows below the glyph and side columns are blank
            if (y == 0 || y > 14 || x < 1 || x > 5) begin
                return 1'b0;
            end
            dots = glyph_dots(screen_codes[row * TERM_COLS + col], (y - 1) / 2);
            return dots[5 - x];
        endfunction

        // Advance the mirror by one accepted request and queue its result
        function void take_request(logic op, logic [CHAR_W-1:0] code,
                                   logic [PIXEL_X_W-1:0] px, logic [PIXEL_Y_W-1:0] py);
            pixel_result_t want;
            want = '0;
            if (op == OP_PUT) begin
                puts++;
                print_code(code);
            end else begin
                fetches++;
                want.pixel_on = pixel_lit(px, py);
                if (want.pixel_on) begin
                    lit++;
                end
                want.red   = want.pixel_on ? RED_LIT   : RED_DARK;
                want.green = want.pixel_on ? GREEN_LIT : GREEN_DARK;
                want.blue  = want.pixel_on ? BLUE_LIT  : BLUE_DARK;
            end
            want.cursor_col = col_now;
            want.cursor_row = row_now;
            awaited = {awaited, want};
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t ns: %s mismatch, expected %0d, got %0d",
                             $time, name, want, got);
                end
            end
        endfunction

        function void check_result(logic [RESULT_W-1:0] bits);
            pixel_result_t got;
            pixel_result_t want;
            got = bits[$bits(pixel_result_t)-1:0];
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t ns: result with nothing expected, got %h", $time, bits);
                end
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            checked++;
            compare_field("pixel_on", want.pixel_on, got.pixel_on);
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("cursor_col", want.cursor_col, got.cursor_col);
            compare_field("cursor_row", want.cursor_row, got.cursor_row);
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [REQUEST_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = OP_PUT;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [RESULT_W-1:0]  m_tdata;

    screen_scoreboard tracker = new();
    int               cycle_count = 0;
    int               burst_left  = 0;
    int               sent        = 0;
    logic [7:0]       ready_pattern = 8'hff;
    int               ready_phase   = 0;
    string            glyph_chars =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.,:-/! ";

    text_terminal_display_unit #(
        .COLUMNS    (TERM_COLS),
        .ROWS       (TERM_ROWS),
        .CELL_WIDTH (GLYPH_W),
        .CELL_HEIGHT(GLYPH_H)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Check every result the block hands over
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_result(m_tdata);
        end
    end

    // Stall the result side on a random ready pattern, drawn anew each time ready_phase runs down to zero
    always @(negedge aclk) begin
        if (ready_phase == 0) begin
            ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom | 32'h01);
            ready_phase   = 63;
        end else begin
            ready_phase = ready_phase - 1;
        end
        m_tready <= ready_pattern[ready_phase % 8];
    end

    // Drive one request in bursts with random gaps; hold until it is taken
    task automatic send_request(logic op, logic [CHAR_W-1:0] code,
                                logic [PIXEL_X_W-1:0] px, logic [PIXEL_Y_W-1:0] py);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(REQUEST_W - PIXEL_Y_W - PIXEL_X_W - CHAR_W){1'b0}}, py, px, code};
        do @(posedge aclk); while (!s_tready);
        tracker.take_request(op, code, px, py);
        sent++;
        @(negedge aclk);
    endtask

    task automatic put_code(logic [CHAR_W-1:0] code);
        send_request(OP_PUT, code, PIXEL_X_W'($urandom), PIXEL_Y_W'($urandom));
    endtask

    task automatic fetch_pixel(int px, int py);
        send_request(OP_FETCH, CHAR_W'($urandom), PIXEL_X_W'(px), PIXEL_Y_W'(py));
    endtask

    task automatic fetch_glyph_pixel(int col, int row, int x, int y);
        fetch_pixel(col * GLYPH_W + x, row * GLYPH_H + y);
    endtask

    task automatic put_random_code();
        int k;
        k = $urandom_range(0, 99);
        if (k < 6) begin
            put_code(LF_CODE);
        end else if (k < 9) begin
            put_code(CR_CODE);
        end else if (k < 12) begin
            put_code(BS_CODE);
        end else if (k < 14) begin
            put_code(CHAR_W'($urandom_range(0, SPACE_CODE - 1)));
        end else if (k < 18) begin
            put_code(CHAR_W'($urandom_range(8'h7f, 8'hff)));
        end else if (k < 20) begin
            put_code(CHAR_W'($urandom_range(0, 255)));
        end else begin
            put_code(glyph_chars[$urandom_range(0, glyph_chars.len() - 1)]);
        end
    endtask

    task automatic fetch_random_pixel();
        int k;
        int row;
        int col;
        int x;
        int y;
        k = $urandom_range(0, 99);
        if (k < 10) begin
            fetch_pixel($urandom_range(0, 1023), $urandom_range(0, 511));
        end else begin
            // aim mostly at the line being written and at the glyph area
            row = $urandom_range(0, 1) ? int'(tracker.row_now) : $urandom_range(0, TERM_ROWS - 1);
            if (row == tracker.row_now && $urandom_range(0, 1)) begin
                col = $urandom_range(0, tracker.col_now);
            end else begin
                col = $urandom_range(0, TERM_COLS - 1);
            end
            x = (k < 25) ? $urandom_range(0, GLYPH_W - 1) : $urandom_range(1, 5);
            y = (k < 25) ? $urandom_range(0, GLYPH_H - 1) : $urandom_range(1, 14);
            fetch_glyph_pixel(col, row, x, y);
        end
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("Timeout after %0d cycles, %0d results still owed",
                 cycle_count, tracker.outstanding());
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int pick;
        int n;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Blank screen: top pixel row, far outside the screen, last pixel inside
        fetch_pixel(0, 0);
        fetch_pixel(1023, 511);
        fetch_pixel(639, 383);

        // Upper and lower case share a glyph
        put_code("A");
        fetch_glyph_pixel(0, 0, 1, 1);
        fetch_glyph_pixel(0, 0, 3, 1);
        put_code("a");
        fetch_glyph_pixel(1, 0, 1, 7);

        // A stored code without glyph, an ignored control code, backspace
        put_code(8'hff);
        fetch_glyph_pixel(2, 0, 3, 7);
        put_code(8'h01);
        put_code(BS_CODE);
        put_code(CR_CODE);
        // backspace at column zero keeps the cursor and blanks the cell
        put_code(BS_CODE);
        fetch_glyph_pixel(0, 0, 3, 1);

        // Punctuation glyphs, then a line feed
        put_code("/");
        put_code("!");
        put_code(".");
        put_code(",");
        put_code(":");
        put_code("-");
        put_code(LF_CODE);
        fetch_glyph_pixel(0, 0, 5, 15);
        fetch_glyph_pixel(0, 0, 0, 11);

        // Random mix of text, control codes and pixel fetches
        while (sent < DIRECTED + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 999);
            if (pick < 4) begin
                // a line of 70 to 90 codes, long enough that it can wrap
                n = $urandom_range(70, 90);
                repeat (n) put_code(glyph_chars[$urandom_range(0, glyph_chars.len() - 1)]);
            end else if (pick < 480) begin
                fetch_random_pixel();
            end else begin
                put_random_code();
            end
        end

        // Drain the results, then watch for strays
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d requests: %0d character writes, %0d pixel fetches (%0d lit)",
                 sent, tracker.puts, tracker.fetches, tracker.lit);
        $display("Saw %0d scrolls and %0d line wraps; %0d results checked, %0d mismatches",
                 tracker.scrolls, tracker.wraps, tracker.checked, tracker.errors);
        if (tracker.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
